/* src/pos_list_pkg.sv */
// Package for the positional list block: capacity, widths, opcode and status codes.
// Used by positional_list_insert_delete; depends on nothing else.
package pos_list_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned WORD_W   = 32;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_BOUNDS  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [7:0] POS_TAIL = 8'hFF;

endpackage

/* src/positional_list_insert_delete.sv */
// Positional list held in a 1R1W synchronous RAM; insert/delete shift one entry per cycle.
// Insert/delete word out the cycle after accept. Insert shifts the entries from the index up
// one place, then writes the new word (no shift on append); delete shifts the later entries
// down one place (no shift when the last entry goes). Traverse streams every word in order,
// one per cycle unless the output stalls; new requests wait until idle and output free.
// Reset clears the element count and control state; RAM contents are not cleared.
module positional_list_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic signed [7:0]  position_i,
  input  logic signed [31:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] value_out_o,
  output logic        is_last_o,
  output logic [4:0]  count_o,
  output logic        empty_res_o
);

  localparam int unsigned IDX_W  = pos_list_pkg::IDX_W;
  localparam int unsigned CNT_W  = pos_list_pkg::CNT_W;
  localparam int unsigned WORD_W = pos_list_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PLACE = 4'b0100,
    S_TRAV  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ins_q, ins_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              wb_pend_q, wb_pend_d;
  logic [IDX_W-1:0]  wb_addr_q, wb_addr_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  tr_rd_q, tr_rd_d;
  logic [CNT_W-1:0]  tr_em_q, tr_em_d;
  logic              tr_pend_q, tr_pend_d;

  // RAM
  logic [WORD_W-1:0] mem [pos_list_pkg::CAPACITY];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  // output word register
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [WORD_W-1:0] value_q;
  logic              last_q;
  logic [CNT_W-1:0]  count_q;
  logic              empty_q;

  logic              res_load;
  logic [2:0]        res_status;
  logic [WORD_W-1:0] res_value;
  logic              res_last;
  logic [CNT_W-1:0]  res_count;

  logic out_free, accept;
  logic pos_tail, pos_bad;
  logic [7:0] pos_raw, cnt8;
  logic [CNT_W-1:0] ins_idx, del_idx, del_left;
  logic [2:0] ins_st, del_st;
  logic trav_load, trav_issue, trav_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // position decode
  assign pos_tail = (position_i == pos_list_pkg::POS_TAIL);
  assign pos_bad  = position_i[7] && !pos_tail;
  assign pos_raw  = {1'b0, position_i[6:0]};
  assign cnt8     = 8'(cnt_q);
  assign ins_idx  = pos_tail ? cnt_q : CNT_W'(position_i[6:0]);
  assign del_idx  = pos_tail ? CNT_W'(cnt_q - 1'b1) : CNT_W'(position_i[6:0]);
  assign del_left = CNT_W'(cnt_q - 1'b1 - del_idx);

  always_comb begin
    priority if (pos_bad) begin
      ins_st = pos_list_pkg::ST_INVALID;
    end else if (!pos_tail && (pos_raw > cnt8)) begin
      ins_st = pos_list_pkg::ST_BOUNDS;
    end else if (cnt_q == CNT_W'(pos_list_pkg::CAPACITY)) begin
      ins_st = pos_list_pkg::ST_FULL;
    end else begin
      ins_st = pos_list_pkg::ST_OK;
    end
  end

  always_comb begin
    priority if (cnt_q == '0) begin
      del_st = pos_list_pkg::ST_EMPTY;
    end else if (pos_bad) begin
      del_st = pos_list_pkg::ST_INVALID;
    end else if (!pos_tail && (pos_raw >= cnt8)) begin
      del_st = pos_list_pkg::ST_BOUNDS;
    end else begin
      del_st = pos_list_pkg::ST_OK;
    end
  end

  // traverse streaming: a read may issue while the previous word is handed over
  assign trav_load  = (state_q == S_TRAV) && tr_pend_q && out_free;
  assign trav_issue = (state_q == S_TRAV) && (tr_rd_q != cnt_q) && (!tr_pend_q || trav_load);
  assign trav_last  = (tr_em_q == CNT_W'(cnt_q - 1'b1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ins_d     = ins_q;
    left_d    = left_q;
    rd_ptr_d  = rd_ptr_q;
    wb_pend_d = wb_pend_q;
    wb_addr_d = wb_addr_q;
    idx_d     = idx_q;
    val_d     = val_q;
    tr_rd_d   = tr_rd_q;
    tr_em_d   = tr_em_q;
    tr_pend_d = tr_pend_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    res_load   = 1'b0;
    res_status = pos_list_pkg::ST_OK;
    res_value  = '0;
    res_last   = 1'b1;
    res_count  = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == pos_list_pkg::OP_INSERT) begin
            res_load   = 1'b1;
            res_status = ins_st;
            if (ins_st == pos_list_pkg::ST_OK) begin
              cnt_d     = CNT_W'(cnt_q + 1'b1);
              res_count = CNT_W'(cnt_q + 1'b1);
              idx_d     = IDX_W'(ins_idx);
              val_d     = value_in_i;
              ins_d     = 1'b1;
              if (cnt_q != ins_idx) begin
                left_d   = CNT_W'(cnt_q - ins_idx);
                rd_ptr_d = IDX_W'(cnt_q - 1'b1);
                state_d  = S_SHIFT;
              end else begin
                state_d  = S_PLACE;
              end
            end
          end else if (opcode_i == pos_list_pkg::OP_DELETE) begin
            res_load   = 1'b1;
            res_status = del_st;
            if (del_st == pos_list_pkg::ST_OK) begin
              cnt_d     = CNT_W'(cnt_q - 1'b1);
              res_count = CNT_W'(cnt_q - 1'b1);
              ins_d     = 1'b0;
              if (del_left != '0) begin
                left_d   = del_left;
                rd_ptr_d = IDX_W'(del_idx + 1'b1);
                state_d  = S_SHIFT;
              end
            end
          end else if (opcode_i == pos_list_pkg::OP_TRAVERSE) begin
            if (cnt_q == '0) begin
              res_load   = 1'b1;
              res_status = pos_list_pkg::ST_EMPTY;
            end else begin
              tr_rd_d   = '0;
              tr_em_d   = '0;
              tr_pend_d = 1'b0;
              state_d   = S_TRAV;
            end
          end
        end
      end

      S_SHIFT: begin
        // read one entry, write it one place over on the next cycle
        if (left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q;
          left_d    = CNT_W'(left_q - 1'b1);
          wb_pend_d = 1'b1;
          rd_ptr_d  = ins_q ? IDX_W'(rd_ptr_q - 1'b1) : IDX_W'(rd_ptr_q + 1'b1);
          wb_addr_d = ins_q ? IDX_W'(rd_ptr_q + 1'b1) : IDX_W'(rd_ptr_q - 1'b1);
        end else begin
          wb_pend_d = 1'b0;
        end
        if (wb_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wb_addr_q;
          mem_wdata = rdata_q;
        end
        if ((left_q == '0) && !wb_pend_q) begin
          state_d = ins_q ? S_PLACE : S_IDLE;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = val_q;
        state_d   = S_IDLE;
      end

      S_TRAV: begin
        if (trav_issue) begin
          mem_re    = 1'b1;
          mem_raddr = tr_rd_q[IDX_W-1:0];
          tr_rd_d   = CNT_W'(tr_rd_q + 1'b1);
        end
        tr_pend_d = trav_issue ? 1'b1 : (trav_load ? 1'b0 : tr_pend_q);
        if (trav_load) begin
          res_load  = 1'b1;
          res_value = rdata_q;
          res_last  = trav_last;
          tr_em_d   = CNT_W'(tr_em_q + 1'b1);
          if (trav_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ins_q       <= 1'b0;
      left_q      <= '0;
      rd_ptr_q    <= '0;
      wb_pend_q   <= 1'b0;
      wb_addr_q   <= '0;
      tr_rd_q     <= '0;
      tr_em_q     <= '0;
      tr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ins_q       <= ins_d;
      left_q      <= left_d;
      rd_ptr_q    <= rd_ptr_d;
      wb_pend_q   <= wb_pend_d;
      wb_addr_q   <= wb_addr_d;
      tr_rd_q     <= tr_rd_d;
      tr_em_q     <= tr_em_d;
      tr_pend_q   <= tr_pend_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    if (res_load) begin
      status_q <= res_status;
      value_q  <= res_value;
      last_q   <= res_last;
      count_q  <= res_count;
      empty_q  <= (res_count == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;
  assign is_last_o   = last_q;
  assign count_o     = 5'(count_q);
  assign empty_res_o = empty_q;

endmodule
